### hw/rtl/svpwm_pkg.sv
// Shared types and constants of the space vector PWM duty pipeline.
package svpwm_pkg;

    localparam int IN_W   = 16;  // Q2.14 input component
    localparam int SQ_W   = 32;  // squared length, Q4.28
    localparam int RAD_W  = 48;  // radicand, Q4.44
    localparam int ROOT_W = 24;  // vector length, Q22
    localparam int NUM_W  = 39;  // dividend: |component| * sqrt3/2 * 4
    localparam int QUO_W  = 17;  // scaled component magnitude, Q16
    localparam int VEC_W  = 18;  // signed component, Q16
    localparam int PROD_W = 36;  // component times 1/sqrt3 or 2/sqrt3
    localparam int COMP_W = 20;  // a, b, c, x, y
    localparam int SUM_W  = 22;  // x + y, z, half z
    localparam int DSUM_W = 23;  // unrounded duty, Q16
    localparam int DUTY_W = 16;  // output duty, Q1.15

    localparam logic [SQ_W-1:0]           LIMIT_SQ_Q28      = 32'd201326592;
    localparam logic [NUM_W-1:0]          HALF_SQRT3_X4_Q22 = 39'd14529496;
    localparam logic signed [PROD_W-1:0]  INV_SQRT3_Q16     = 36'sd37837;
    localparam logic signed [PROD_W-1:0]  TWO_INV_SQRT3_Q16 = 36'sd75674;
    localparam logic signed [PROD_W-1:0]  ROUND_Q16         = 36'sd32768;
    localparam logic signed [SUM_W-1:0]   ONE_Q16           = 22'sd65536;
    localparam logic signed [DSUM_W-1:0]  DUTY_ONE_Q15      = 23'sd32768;

    typedef logic [2:0] sector_t;
    localparam sector_t SECTOR_1 = 3'd1;
    localparam sector_t SECTOR_2 = 3'd2;
    localparam sector_t SECTOR_3 = 3'd3;
    localparam sector_t SECTOR_4 = 3'd4;
    localparam sector_t SECTOR_5 = 3'd5;
    localparam sector_t SECTOR_6 = 3'd6;

    // Request fields carried alongside the arithmetic.
    typedef struct packed {
        logic signed [IN_W-1:0] alpha;
        logic signed [IN_W-1:0] beta;
        logic                   limited;
    } side_t;

endpackage

### hw/rtl/svpwm_isqrt.sv
// Pipelined integer square root, one result bit per stage.
module svpwm_isqrt (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           pipe_en,
    input  logic                           in_valid,
    input  svpwm_pkg::side_t               in_side,
    input  logic [svpwm_pkg::RAD_W-1:0]    in_rad,
    output logic                           out_valid,
    output svpwm_pkg::side_t               out_side,
    output logic [svpwm_pkg::ROOT_W-1:0]   out_root
);

    localparam int STAGES = svpwm_pkg::ROOT_W;
    localparam int RW     = svpwm_pkg::RAD_W;

    logic             vld_reg  [STAGES];
    svpwm_pkg::side_t side_reg [STAGES];
    logic [RW-1:0]    rem_reg  [STAGES];
    logic [RW-1:0]    res_reg  [STAGES];

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        localparam logic [RW-1:0] BIT = {{(RW-1){1'b0}}, 1'b1} << (2 * (STAGES - 1 - k));
        logic             vld_in;
        svpwm_pkg::side_t side_in;
        logic [RW-1:0]    rem_in, res_in, trial, rem_next, res_next;

        if (k == 0) begin : g_first
            assign vld_in  = in_valid;
            assign side_in = in_side;
            assign rem_in  = in_rad;
            assign res_in  = '0;
        end else begin : g_next
            assign vld_in  = vld_reg[k-1];
            assign side_in = side_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign res_in  = res_reg[k-1];
        end

        assign trial = res_in + BIT;

        always_comb begin
            if (rem_in >= trial) begin
                rem_next = rem_in - trial;
                res_next = (res_in >> 1) + BIT;
            end else begin
                rem_next = rem_in;
                res_next = res_in >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (pipe_en) begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (pipe_en) begin
                side_reg[k] <= side_in;
                rem_reg[k]  <= rem_next;
                res_reg[k]  <= res_next;
            end
        end
    end

    assign out_valid = vld_reg[STAGES-1];
    assign out_side  = side_reg[STAGES-1];
    assign out_root  = res_reg[STAGES-1][svpwm_pkg::ROOT_W-1:0];

endmodule

### hw/rtl/svpwm_div.sv
// Pipelined restoring divider, two dividends over one shared divisor.
module svpwm_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           pipe_en,
    input  logic                           in_valid,
    input  svpwm_pkg::side_t               in_side,
    input  logic [svpwm_pkg::ROOT_W-1:0]   in_len,
    input  logic [svpwm_pkg::NUM_W-1:0]    in_num_a,
    input  logic [svpwm_pkg::NUM_W-1:0]    in_num_b,
    output logic                           out_valid,
    output svpwm_pkg::side_t               out_side,
    output logic [svpwm_pkg::QUO_W-1:0]    out_quo_a,
    output logic [svpwm_pkg::QUO_W-1:0]    out_quo_b
);

    localparam int STAGES = svpwm_pkg::QUO_W;
    localparam int LW     = svpwm_pkg::ROOT_W;
    localparam int NW     = svpwm_pkg::NUM_W;

    logic             vld_reg  [STAGES];
    svpwm_pkg::side_t side_reg [STAGES];
    logic [LW-1:0]    len_reg  [STAGES];
    logic [NW-1:0]    num_reg  [STAGES][2];
    logic [LW-1:0]    rem_reg  [STAGES][2];
    logic [STAGES-1:0] quo_reg [STAGES][2];

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        logic              vld_in;
        svpwm_pkg::side_t  side_in;
        logic [LW-1:0]     len_in;
        logic [NW-1:0]     num_in  [2];
        logic [LW-1:0]     rem_in  [2];
        logic [STAGES-1:0] quo_in  [2];
        logic [LW-1:0]     rem_next [2];
        logic [STAGES-1:0] quo_next [2];

        if (k == 0) begin : g_first
            assign vld_in    = in_valid;
            assign side_in   = in_side;
            assign len_in    = in_len;
            assign num_in[0] = in_num_a;
            assign num_in[1] = in_num_b;
            assign rem_in[0] = LW'(in_num_a[NW-1:STAGES]);
            assign rem_in[1] = LW'(in_num_b[NW-1:STAGES]);
            assign quo_in[0] = '0;
            assign quo_in[1] = '0;
        end else begin : g_next
            assign vld_in    = vld_reg[k-1];
            assign side_in   = side_reg[k-1];
            assign len_in    = len_reg[k-1];
            assign num_in[0] = num_reg[k-1][0];
            assign num_in[1] = num_reg[k-1][1];
            assign rem_in[0] = rem_reg[k-1][0];
            assign rem_in[1] = rem_reg[k-1][1];
            assign quo_in[0] = quo_reg[k-1][0];
            assign quo_in[1] = quo_reg[k-1][1];
        end

        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic [LW:0] trial;
            logic        ge;
            assign trial = {rem_in[l], num_in[l][STAGES-1-k]};
            assign ge    = (trial >= {1'b0, len_in});

            always_comb begin
                if (ge) begin
                    rem_next[l] = LW'(trial - {1'b0, len_in});
                end else begin
                    rem_next[l] = trial[LW-1:0];
                end
                quo_next[l] = {quo_in[l][STAGES-2:0], ge};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (pipe_en) begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (pipe_en) begin
                side_reg[k]   <= side_in;
                len_reg[k]    <= len_in;
                num_reg[k][0] <= num_in[0];
                num_reg[k][1] <= num_in[1];
                rem_reg[k][0] <= rem_next[0];
                rem_reg[k][1] <= rem_next[1];
                quo_reg[k][0] <= quo_next[0];
                quo_reg[k][1] <= quo_next[1];
            end
        end
    end

    assign out_valid = vld_reg[STAGES-1];
    assign out_side  = side_reg[STAGES-1];
    assign out_quo_a = quo_reg[STAGES-1][0];
    assign out_quo_b = quo_reg[STAGES-1][1];

endmodule

### hw/rtl/svpwm_duty.sv
// Clarke-to-sector transform, zero vector split and duty saturation (four stages).
module svpwm_duty (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           pipe_en,
    input  logic                           in_valid,
    input  svpwm_pkg::side_t               in_side,
    input  logic [svpwm_pkg::QUO_W-1:0]    in_quo_a,
    input  logic [svpwm_pkg::QUO_W-1:0]    in_quo_b,
    output logic                           out_valid,
    output logic [svpwm_pkg::DUTY_W-1:0]   out_duty_u,
    output logic [svpwm_pkg::DUTY_W-1:0]   out_duty_v,
    output logic [svpwm_pkg::DUTY_W-1:0]   out_duty_w,
    output svpwm_pkg::sector_t             out_sector,
    output logic                           out_limited
);

    localparam int VW = svpwm_pkg::VEC_W;
    localparam int PW = svpwm_pkg::PROD_W;
    localparam int CW = svpwm_pkg::COMP_W;
    localparam int SW = svpwm_pkg::SUM_W;
    localparam int DW = svpwm_pkg::DSUM_W;

    // stage 1: pick scaled or widened vector, multiply beta
    logic signed [VW-1:0] al_next, be_next, al1_reg;
    logic signed [PW-1:0] pb1_next, pb2_next, pb1_reg, pb2_reg;
    logic                 lim1_reg, vld1_reg;

    always_comb begin
        if (in_side.limited) begin
            al_next = in_side.alpha[15] ? -$signed({1'b0, in_quo_a}) : $signed({1'b0, in_quo_a});
            be_next = in_side.beta[15]  ? -$signed({1'b0, in_quo_b}) : $signed({1'b0, in_quo_b});
        end else begin
            al_next = {in_side.alpha, 2'b00};
            be_next = {in_side.beta, 2'b00};
        end
        pb1_next = PW'(be_next) * svpwm_pkg::INV_SQRT3_Q16;
        pb2_next = PW'(be_next) * svpwm_pkg::TWO_INV_SQRT3_Q16;
    end

    // stage 2: a, b, c and sector
    logic signed [PW-1:0] r1_sum, r2_sum;
    logic signed [CW-1:0] a_next, b_next, c_next, a2_reg, b2_reg, c2_reg;
    svpwm_pkg::sector_t   sec_next, sec2_reg;
    logic                 lim2_reg, vld2_reg;

    always_comb begin
        r1_sum = pb1_reg + svpwm_pkg::ROUND_Q16;
        r2_sum = pb2_reg + svpwm_pkg::ROUND_Q16;
        a_next = CW'(al1_reg) - $signed(r1_sum[PW-1:16]);
        b_next = $signed(r2_sum[PW-1:16]);
        c_next = -(a_next + b_next);
        if (c_next < 0) begin
            sec_next = (a_next < 0) ? svpwm_pkg::SECTOR_2 :
                       ((b_next < 0) ? svpwm_pkg::SECTOR_6 : svpwm_pkg::SECTOR_1);
        end else begin
            sec_next = (a_next >= 0) ? svpwm_pkg::SECTOR_5 :
                       ((b_next <= 0) ? svpwm_pkg::SECTOR_4 : svpwm_pkg::SECTOR_3);
        end
    end

    // stage 3: x, y and half of the zero-vector time
    logic signed [CW-1:0] x_next, y_next, x3_reg, y3_reg;
    logic signed [SW-1:0] s_next, z_next, s3_reg, h3_reg;
    svpwm_pkg::sector_t   sec3_reg;
    logic                 lim3_reg, vld3_reg;

    always_comb begin
        unique case (sec2_reg)
            svpwm_pkg::SECTOR_1: begin x_next = a2_reg;  y_next = b2_reg;  end
            svpwm_pkg::SECTOR_2: begin x_next = -c2_reg; y_next = -a2_reg; end
            svpwm_pkg::SECTOR_3: begin x_next = b2_reg;  y_next = c2_reg;  end
            svpwm_pkg::SECTOR_4: begin x_next = -a2_reg; y_next = -b2_reg; end
            svpwm_pkg::SECTOR_5: begin x_next = c2_reg;  y_next = a2_reg;  end
            default:             begin x_next = -b2_reg; y_next = -c2_reg; end
        endcase
        s_next = SW'(x_next) + SW'(y_next);
        z_next = svpwm_pkg::ONE_Q16 - s_next;
    end

    // stage 4: phase sums, round to Q15, clamp
    logic signed [DW-1:0] du_sum, dv_sum, dw_sum, xs, ys, ss, hs;
    logic [svpwm_pkg::DUTY_W-1:0] du_next, dv_next, dw_next;
    logic [svpwm_pkg::DUTY_W-1:0] du4_reg, dv4_reg, dw4_reg;
    svpwm_pkg::sector_t   sec4_reg;
    logic                 lim4_reg, vld4_reg;

    function automatic logic [svpwm_pkg::DUTY_W-1:0] to_duty(logic signed [DW-1:0] d);
        logic signed [DW-1:0] r;
        r = (d + DW'(1)) >>> 1;
        if (r < 0) begin
            return '0;
        end else if (r > svpwm_pkg::DUTY_ONE_Q15) begin
            return svpwm_pkg::DUTY_W'(svpwm_pkg::DUTY_ONE_Q15);
        end else begin
            return r[svpwm_pkg::DUTY_W-1:0];
        end
    endfunction

    always_comb begin
        xs = DW'(x3_reg);
        ys = DW'(y3_reg);
        ss = DW'(s3_reg);
        hs = DW'(h3_reg);
        unique case (sec3_reg)
            svpwm_pkg::SECTOR_1: begin du_sum = ss + hs; dv_sum = ys + hs; dw_sum = hs;      end
            svpwm_pkg::SECTOR_2: begin du_sum = xs + hs; dv_sum = ss + hs; dw_sum = hs;      end
            svpwm_pkg::SECTOR_3: begin du_sum = hs;      dv_sum = ss + hs; dw_sum = ys + hs; end
            svpwm_pkg::SECTOR_4: begin du_sum = hs;      dv_sum = xs + hs; dw_sum = ss + hs; end
            svpwm_pkg::SECTOR_5: begin du_sum = ys + hs; dv_sum = hs;      dw_sum = ss + hs; end
            default:             begin du_sum = ss + hs; dv_sum = hs;      dw_sum = xs + hs; end
        endcase
        du_next = to_duty(du_sum);
        dv_next = to_duty(dv_sum);
        dw_next = to_duty(dw_sum);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
        end else if (pipe_en) begin
            vld1_reg <= in_valid;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
            vld4_reg <= vld3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            al1_reg  <= al_next;
            pb1_reg  <= pb1_next;
            pb2_reg  <= pb2_next;
            lim1_reg <= in_side.limited;
            a2_reg   <= a_next;
            b2_reg   <= b_next;
            c2_reg   <= c_next;
            sec2_reg <= sec_next;
            lim2_reg <= lim1_reg;
            x3_reg   <= x_next;
            y3_reg   <= y_next;
            s3_reg   <= s_next;
            h3_reg   <= z_next >>> 1;
            sec3_reg <= sec2_reg;
            lim3_reg <= lim2_reg;
            du4_reg  <= du_next;
            dv4_reg  <= dv_next;
            dw4_reg  <= dw_next;
            sec4_reg <= sec3_reg;
            lim4_reg <= lim3_reg;
        end
    end

    assign out_valid   = vld4_reg;
    assign out_duty_u  = du4_reg;
    assign out_duty_v  = dv4_reg;
    assign out_duty_w  = dw4_reg;
    assign out_sector  = sec4_reg;
    assign out_limited = lim4_reg;

endmodule

### hw/rtl/space_vector_pwm_duty.sv
// Top level of the space vector PWM duty generator.
//
// Usage: one request on the s_ channel carries an alpha-beta voltage vector
// (signed Q2.14). Each request yields exactly one result on the m_ channel:
// three phase duties (unsigned Q1.15, 0..32768), the sector 1..6 and a flag
// that is set when the vector was pulled back to radius sqrt(3)/2.
// Pipeline stages from accept to m_valid, in order:
//   2 (square and sum) + 24 (square root, one bit per stage)
//   + 1 (dividend multiply) + 17 (divider, one quotient bit per stage)
//   + 4 (sector transform, zero-vector split, rounding and clamp).
// Throughput: one request per cycle while the output is not stalled; the pipeline has no feedback.
// Stall: the whole pipeline holds when the output stage is full and
// m_ready is low; s_ready drops in the same cycle, so nothing is lost or
// repeated. Results come out in request order.
// Reset: synchronous, active low; clears all stage valid bits, so the
// pipeline comes up empty and ready.
module space_vector_pwm_duty (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [15:0]  s_alpha_voltage,
    input  logic signed [15:0]  s_beta_voltage,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [15:0]         m_duty_phase_u,
    output logic [15:0]         m_duty_phase_v,
    output logic [15:0]         m_duty_phase_w,
    output logic [2:0]          m_sector_number,
    output logic                m_magnitude_limited
);

    // Global advance: a bubble or a taken result at the output lets all stages move.
    logic pipe_en;
    assign pipe_en = !m_valid || m_ready;
    assign s_ready = pipe_en;

    // Stage 1: squares of the components.
    logic                                vld1_reg;
    logic signed [15:0]                  al1_reg, be1_reg;
    logic signed [svpwm_pkg::SQ_W-1:0]   sqa1_reg, sqb1_reg;

    // Stage 2: squared length and the limit decision.
    logic                                vld2_reg;
    svpwm_pkg::side_t                    side2_reg, side2_next;
    logic [svpwm_pkg::SQ_W-1:0]          sq2_reg, sq_next;

    always_comb begin
        sq_next            = sqa1_reg + sqb1_reg;
        side2_next.alpha   = al1_reg;
        side2_next.beta    = be1_reg;
        side2_next.limited = (sq_next > svpwm_pkg::LIMIT_SQ_Q28);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end else if (pipe_en) begin
            vld1_reg <= s_valid;
            vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            al1_reg   <= s_alpha_voltage;
            be1_reg   <= s_beta_voltage;
            sqa1_reg  <= s_alpha_voltage * s_alpha_voltage;
            sqb1_reg  <= s_beta_voltage * s_beta_voltage;
            side2_reg <= side2_next;
            sq2_reg   <= sq_next;
        end
    end

    // Vector length in Q22, computed for every request; used only when limited.
    logic                                 root_valid;
    svpwm_pkg::side_t                     root_side;
    logic [svpwm_pkg::ROOT_W-1:0]         root_len;

    svpwm_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pipe_en   (pipe_en),
        .in_valid  (vld2_reg),
        .in_side   (side2_reg),
        .in_rad    ({sq2_reg, 16'h0000}),
        .out_valid (root_valid),
        .out_side  (root_side),
        .out_root  (root_len)
    );

    // Dividend stage: |component| * sqrt(3)/2 (Q22) * 4.
    logic                                 vldm_reg;
    svpwm_pkg::side_t                     sidem_reg;
    logic [svpwm_pkg::ROOT_W-1:0]         lenm_reg;
    logic [svpwm_pkg::NUM_W-1:0]          numa_reg, numb_reg;
    logic [16:0]                          maga_wide, magb_wide;

    assign maga_wide = root_side.alpha[15] ? (17'd0 - {1'b1, root_side.alpha})
                                           : {1'b0, root_side.alpha};
    assign magb_wide = root_side.beta[15]  ? (17'd0 - {1'b1, root_side.beta})
                                           : {1'b0, root_side.beta};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vldm_reg <= 1'b0;
        end else if (pipe_en) begin
            vldm_reg <= root_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            sidem_reg <= root_side;
            lenm_reg  <= root_len;
            numa_reg  <= svpwm_pkg::NUM_W'(maga_wide[15:0]) * svpwm_pkg::HALF_SQRT3_X4_Q22;
            numb_reg  <= svpwm_pkg::NUM_W'(magb_wide[15:0]) * svpwm_pkg::HALF_SQRT3_X4_Q22;
        end
    end

    // Scaled component magnitudes in Q16.
    logic                                 quo_valid;
    svpwm_pkg::side_t                     quo_side;
    logic [svpwm_pkg::QUO_W-1:0]          quo_a, quo_b;

    svpwm_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pipe_en   (pipe_en),
        .in_valid  (vldm_reg),
        .in_side   (sidem_reg),
        .in_len    (lenm_reg),
        .in_num_a  (numa_reg),
        .in_num_b  (numb_reg),
        .out_valid (quo_valid),
        .out_side  (quo_side),
        .out_quo_a (quo_a),
        .out_quo_b (quo_b)
    );

    // Sector selection and duty computation; its last stage is the output register.
    svpwm_duty u_duty (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .pipe_en     (pipe_en),
        .in_valid    (quo_valid),
        .in_side     (quo_side),
        .in_quo_a    (quo_a),
        .in_quo_b    (quo_b),
        .out_valid   (m_valid),
        .out_duty_u  (m_duty_phase_u),
        .out_duty_v  (m_duty_phase_v),
        .out_duty_w  (m_duty_phase_w),
        .out_sector  (m_sector_number),
        .out_limited (m_magnitude_limited)
    );

endmodule
